### rtl/core/sbb_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and lookup functions for the sliding box blur line unit.
package sbb_pkg;

    localparam int MAX_RADIUS   = 30;
    localparam int MAX_LINE     = 1024;
    localparam int SAMPLE_BITS  = 16;
    localparam int STORE_DEPTH  = 2 * MAX_RADIUS + 1;

    localparam int RAD_BITS     = 5;
    localparam int WIN_BITS     = $clog2(STORE_DEPTH + 1);
    localparam int PTR_BITS     = $clog2(STORE_DEPTH);
    localparam int CNT_BITS     = $clog2(MAX_LINE) + 1;
    localparam int POS_BITS     = 10;
    localparam int PIX_BITS     = 3 * SAMPLE_BITS;
    localparam int SUM_BITS     = SAMPLE_BITS + WIN_BITS;
    localparam int GAIN_BITS    = 16;
    localparam int GAIN_FRAC    = 12;
    localparam int PROD_BITS    = SUM_BITS + GAIN_BITS;
    localparam int M_BITS       = PROD_BITS + 1 - GAIN_FRAC;
    localparam int RECIP_BITS   = 32;
    localparam int RECIP_SHIFT  = 33;
    localparam int Q_BITS       = M_BITS - 1;
    localparam int RND_BITS     = WIN_BITS + GAIN_FRAC - 1;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [RAD_BITS-1:0]  RADIUS_RESET = RAD_BITS'(5);
    localparam logic [GAIN_BITS-1:0] GAIN_RESET   = GAIN_BITS'(4096);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_RADIUS = 2'd0,
        REG_GAIN   = 2'd1
    } cfg_reg_t;

    // per-request control from the window to the lanes and sideband pipe
    typedef struct packed {
        logic                take;
        logic                first;
        logic                sub;
        logic                emit;
        logic [POS_BITS-1:0] pos;
        logic [RAD_BITS-1:0] rad;
    } win_ctl_t;

    function automatic logic [RAD_BITS-1:0] eff_radius(input logic [RAD_BITS-1:0] r);
        logic [RAD_BITS-1:0] res;
        if (r == '0)
            res = RAD_BITS'(1);
        else if (r > RAD_BITS'(MAX_RADIUS))
            res = RAD_BITS'(MAX_RADIUS);
        else
            res = r;
        return res;
    endfunction

    // ceil(2^33 / (2r+1)); exact floor division for 27-bit dividends
    function automatic logic [RECIP_BITS-1:0] recip_of(input logic [RAD_BITS-1:0] r);
        logic [RECIP_BITS-1:0] res;
        case (r)
            5'd1:    res = 32'd2863311531;
            5'd2:    res = 32'd1717986919;
            5'd3:    res = 32'd1227133514;
            5'd4:    res = 32'd954437177;
            5'd5:    res = 32'd780903145;
            5'd6:    res = 32'd660764200;
            5'd7:    res = 32'd572662307;
            5'd8:    res = 32'd505290271;
            5'd9:    res = 32'd452101821;
            5'd10:   res = 32'd409044505;
            5'd11:   res = 32'd373475418;
            5'd12:   res = 32'd343597384;
            5'd13:   res = 32'd318145726;
            5'd14:   res = 32'd296204642;
            5'd15:   res = 32'd277094665;
            5'd16:   res = 32'd260301049;
            5'd17:   res = 32'd245426703;
            5'd18:   res = 32'd232160395;
            5'd19:   res = 32'd220254734;
            5'd20:   res = 32'd209510600;
            5'd21:   res = 32'd199765921;
            5'd22:   res = 32'd190887436;
            5'd23:   res = 32'd182764566;
            5'd24:   res = 32'd175304788;
            5'd25:   res = 32'd168430091;
            5'd26:   res = 32'd162074238;
            5'd27:   res = 32'd156180629;
            5'd28:   res = 32'd150700607;
            5'd29:   res = 32'd145592112;
            5'd30:   res = 32'd140818600;
            default: res = 32'd2863311531;
        endcase
        return res;
    endfunction

endpackage

### rtl/core/sbb_window.sv
`timescale 1ns / 1ps
// Line position tracking, pixel delay store and prefetch of the leaving pixel.
module sbb_window
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          line_start,
    input  logic [sbb_pkg::PIX_BITS-1:0]  pixel,
    input  logic [sbb_pkg::RAD_BITS-1:0]  radius_cfg,
    output logic [sbb_pkg::PIX_BITS-1:0]  old_pixel,
    output sbb_pkg::win_ctl_t             ctl
);
    import sbb_pkg::*;

    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RAD_BITS-1:0] line_radius_reg, line_radius_next;
    logic [PIX_BITS-1:0] store_reg [STORE_DEPTH];
    logic [PIX_BITS-1:0] rd_data_reg;

    logic [CNT_BITS-1:0] p_cnt;
    logic [PTR_BITS-1:0] ptr, ptr_inc, rd_addr;
    logic [RAD_BITS-1:0] rad;
    logic [WIN_BITS-1:0] w_next;
    logic [PTR_BITS:0]   diff;
    logic                full, first, take;

    always_comb
    begin
        p_cnt   = line_start ? '0 : count_reg;
        ptr     = line_start ? '0 : wr_ptr_reg;
        full    = (p_cnt >= CNT_BITS'(MAX_LINE));
        first   = (p_cnt == '0);
        take    = accept && !full;
        rad     = first ? eff_radius(radius_cfg) : line_radius_reg;
        ptr_inc = (ptr == PTR_BITS'(STORE_DEPTH - 1)) ? '0 : ptr + 1'b1;

        ctl.take  = take;
        ctl.first = first;
        ctl.sub   = (p_cnt >= CNT_BITS'({rad, 1'b1}));
        ctl.emit  = (p_cnt >= CNT_BITS'({rad, 1'b0}));
        ctl.pos   = POS_BITS'(p_cnt - CNT_BITS'(rad));
        ctl.rad   = rad;

        count_next       = count_reg;
        wr_ptr_next      = wr_ptr_reg;
        line_radius_next = line_radius_reg;
        if (take)
        begin
            count_next       = p_cnt + 1'b1;
            wr_ptr_next      = ptr_inc;
            line_radius_next = rad;
        end

        // address of the pixel that leaves with the next request
        w_next  = {line_radius_next, 1'b1};
        diff    = {1'b0, wr_ptr_next} - (PTR_BITS + 1)'(w_next);
        rd_addr = diff[PTR_BITS] ? PTR_BITS'(diff + (PTR_BITS + 1)'(STORE_DEPTH))
                                 : diff[PTR_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            wr_ptr_reg      <= '0;
            line_radius_reg <= RADIUS_RESET;
        end
        else
        begin
            count_reg       <= count_next;
            wr_ptr_reg      <= wr_ptr_next;
            line_radius_reg <= line_radius_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            store_reg[ptr] <= pixel;
        rd_data_reg <= store_reg[rd_addr];
    end

    assign old_pixel = rd_data_reg;

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_ptr_reg < PTR_BITS'(STORE_DEPTH))
        else $error("write pointer out of store range");

    a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
        take && line_start |=> count_reg == CNT_BITS'(1))
        else $error("line start did not restart the count");

    a_radius_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_radius_reg >= RAD_BITS'(1) && line_radius_reg <= RAD_BITS'(MAX_RADIUS))
        else $error("latched radius out of range");

endmodule

### rtl/core/sbb_lane.sv
`timescale 1ns / 1ps
// One colour lane: running window sum and the gain and averaging pipeline.
module sbb_lane
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  sbb_pkg::win_ctl_t               ctl,
    input  logic [sbb_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [sbb_pkg::SAMPLE_BITS-1:0] old_sample,
    input  logic [sbb_pkg::GAIN_BITS-1:0]   gain,
    input  logic [sbb_pkg::RND_BITS-1:0]    rnd,
    input  logic [sbb_pkg::RECIP_BITS-1:0]  recip,
    output logic [sbb_pkg::Q_BITS-1:0]      quot
);
    import sbb_pkg::*;

    logic [SUM_BITS-1:0]              sum_reg, sum_next, base;
    logic [PROD_BITS-1:0]             prod_reg;
    logic [M_BITS-1:0]                m_reg;
    logic [Q_BITS-1:0]                q_reg;
    logic [PROD_BITS:0]               rounded;
    logic [M_BITS+RECIP_BITS-1:0]     scaled;

    always_comb
    begin
        base     = ctl.first ? '0 : sum_reg;
        sum_next = base - (ctl.sub ? SUM_BITS'(old_sample) : '0) + SUM_BITS'(sample);
        rounded  = {1'b0, prod_reg} + (PROD_BITS + 1)'(rnd);
        scaled   = {{RECIP_BITS{1'b0}}, m_reg} * {{M_BITS{1'b0}}, recip};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else if (ctl.take)
            sum_reg <= sum_next;
    end

    // sum_reg doubles as the first stage: it only moves on an accepted request
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= {{GAIN_BITS{1'b0}}, sum_reg} * {{SUM_BITS{1'b0}}, gain};
            m_reg    <= rounded[PROD_BITS -: M_BITS];
            q_reg    <= scaled[RECIP_SHIFT +: Q_BITS];
        end
    end

    assign quot = q_reg;

endmodule

### rtl/core/sbb_merge.sv
`timescale 1ns / 1ps
// Output stage: saturates the three lane results and registers the result request.
module sbb_merge
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            valid_in,
    input  logic [sbb_pkg::POS_BITS-1:0]    pos_in,
    input  logic [sbb_pkg::Q_BITS-1:0]      q_red,
    input  logic [sbb_pkg::Q_BITS-1:0]      q_green,
    input  logic [sbb_pkg::Q_BITS-1:0]      q_blue,
    output logic                            valid_out,
    output logic [sbb_pkg::SAMPLE_BITS-1:0] red,
    output logic [sbb_pkg::SAMPLE_BITS-1:0] green,
    output logic [sbb_pkg::SAMPLE_BITS-1:0] blue,
    output logic [sbb_pkg::POS_BITS-1:0]    pos
);
    import sbb_pkg::*;

    logic                   valid_reg;
    logic [SAMPLE_BITS-1:0] red_reg, green_reg, blue_reg;
    logic [POS_BITS-1:0]    pos_reg;

    function automatic logic [SAMPLE_BITS-1:0] sat(input logic [Q_BITS-1:0] q);
        logic [SAMPLE_BITS-1:0] res;
        if (q > Q_BITS'({SAMPLE_BITS{1'b1}}))
            res = '1;
        else
            res = q[SAMPLE_BITS-1:0];
        return res;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            red_reg   <= sat(q_red);
            green_reg <= sat(q_green);
            blue_reg  <= sat(q_blue);
            pos_reg   <= pos_in;
        end
    end

    assign valid_out = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign pos       = pos_reg;

endmodule

### rtl/core/sliding_box_blur_line_unit.sv
`timescale 1ns / 1ps
// Top level of the sliding box blur line unit: three colour lanes over a shared window.
//
// Input channel (in_valid/in_stall): one RGB pixel per request, line_start on
// the first pixel of a line. Output channel (out_valid/out_stall): one blurred
// pixel for the window centre, with its position in the line. The first and
// last radius pixels of a line, and pixels past 1024 in a line, give nothing.
// Configuration (cfg_valid/cfg_ready, always ready): index 0 radius, 1 gain;
// radius is latched at the first pixel of each line.
// Throughput: one pixel per cycle while out_stall does not hold the pipe. The
// leaving pixel is prefetched from the 61-entry delay store in the cycle before,
// so the running sums update in the cycle of acceptance.
// Pipeline: after the running sum, a result passes the gain multiply, rounding,
// reciprocal multiply and saturating output registers in that order.
// Stall: while a result waits under out_stall the whole pipe holds and
// in_stall is raised in the same cycle.
// Reset begins a new line; the delay store is not cleared.
module sliding_box_blur_line_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [sbb_pkg::SAMPLE_BITS-1:0]    red_in,
    input  logic [sbb_pkg::SAMPLE_BITS-1:0]    green_in,
    input  logic [sbb_pkg::SAMPLE_BITS-1:0]    blue_in,
    input  logic                               line_start,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [sbb_pkg::SAMPLE_BITS-1:0]    red_out,
    output logic [sbb_pkg::SAMPLE_BITS-1:0]    green_out,
    output logic [sbb_pkg::SAMPLE_BITS-1:0]    blue_out,
    output logic [sbb_pkg::POS_BITS-1:0]       position,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sbb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [sbb_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import sbb_pkg::*;

    logic [RAD_BITS-1:0]   radius_reg;
    logic [GAIN_BITS-1:0]  gain_reg;
    logic [4:1]            stage_valid_reg;
    logic [POS_BITS-1:0]   pos1_reg, pos2_reg, pos3_reg, pos4_reg;
    logic [RAD_BITS-1:0]   rad1_reg, rad2_reg;
    logic [RECIP_BITS-1:0] recip3_reg;

    logic                  adv, accept;
    logic [RND_BITS-1:0]   rnd;
    logic [PIX_BITS-1:0]   old_pixel;
    win_ctl_t              ctl;
    logic [Q_BITS-1:0]     q_red, q_green, q_blue;

    assign adv       = !out_valid || !out_stall;
    assign in_stall  = !adv;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign rnd       = {rad2_reg, 1'b1, {(GAIN_FRAC - 1){1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            gain_reg   <= GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_RADIUS: radius_reg <= cfg_data[RAD_BITS-1:0];
                REG_GAIN:   gain_reg   <= cfg_data[GAIN_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= '0;
        else if (adv)
            stage_valid_reg <= {stage_valid_reg[3:1], ctl.take && ctl.emit};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pos1_reg   <= ctl.pos;
            rad1_reg   <= ctl.rad;
            pos2_reg   <= pos1_reg;
            rad2_reg   <= rad1_reg;
            pos3_reg   <= pos2_reg;
            recip3_reg <= recip_of(rad2_reg);
            pos4_reg   <= pos3_reg;
        end
    end

    sbb_window u_window
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .line_start (line_start),
        .pixel      ({blue_in, green_in, red_in}),
        .radius_cfg (radius_reg),
        .old_pixel  (old_pixel),
        .ctl        (ctl)
    );

    sbb_lane u_lane_red
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .ctl        (ctl),
        .sample     (red_in),
        .old_sample (old_pixel[0 +: SAMPLE_BITS]),
        .gain       (gain_reg),
        .rnd        (rnd),
        .recip      (recip3_reg),
        .quot       (q_red)
    );

    sbb_lane u_lane_green
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .ctl        (ctl),
        .sample     (green_in),
        .old_sample (old_pixel[SAMPLE_BITS +: SAMPLE_BITS]),
        .gain       (gain_reg),
        .rnd        (rnd),
        .recip      (recip3_reg),
        .quot       (q_green)
    );

    sbb_lane u_lane_blue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .ctl        (ctl),
        .sample     (blue_in),
        .old_sample (old_pixel[2*SAMPLE_BITS +: SAMPLE_BITS]),
        .gain       (gain_reg),
        .rnd        (rnd),
        .recip      (recip3_reg),
        .quot       (q_blue)
    );

    sbb_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (stage_valid_reg[4]),
        .pos_in    (pos4_reg),
        .q_red     (q_red),
        .q_green   (q_green),
        .q_blue    (q_blue),
        .valid_out (out_valid),
        .red       (red_out),
        .green     (green_out),
        .blue      (blue_out),
        .pos       (position)
    );

    a_emit_enters: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.take && ctl.emit |=> stage_valid_reg[1])
        else $error("centre result did not enter the pipe");

    a_tail_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg[4] && adv |=> out_valid)
        else $error("last stage result lost");

    a_empty_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg == '0 && adv |=> !out_valid)
        else $error("result produced from an empty pipe");

endmodule
